FILE: hw/rtl/perceptron_branch_predictor_macros.svh
// ----------------------------------------------------------------------------
// Perceptron branch predictor assertion macros
// Shared assertion forms; they use the enclosing module's clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef PERCEPTRON_BRANCH_PREDICTOR_MACROS_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_MACROS_SVH

// same-cycle implication
`define PBP_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define PBP_ASSERT_NXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: hw/rtl/pbp_pkg.sv
// ----------------------------------------------------------------------------
// pbp_pkg
// Fixed constants of the perceptron branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package pbp_pkg;

    localparam int          THETA_W     = 13;
    localparam logic [12:0] THETA_RESET = 13'd75;
    localparam logic [31:0] HASH_MUL    = 32'd19;

    localparam int          APB_ADDR_W  = 3;
    localparam int          APB_DATA_W  = 32;
    localparam logic        REG_THETA   = 1'b0;

    localparam logic        ACT_PREDICT = 1'b0;
    localparam logic        ACT_TRAIN   = 1'b1;

endpackage

`default_nettype wire

FILE: hw/rtl/pbp_row_ram.sv
// ----------------------------------------------------------------------------
// pbp_row_ram
// Weight row memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_row_ram #(
    parameter int ROWS     = 256,
    parameter int ROW_BITS = 264,
    parameter int ADDR_W   = 8
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [ADDR_W-1:0]   waddr,
    input  wire logic [ROW_BITS-1:0] wdata,
    input  wire logic                re,
    input  wire logic [ADDR_W-1:0]   raddr,
    output logic      [ROW_BITS-1:0] rdata
);

    logic [ROW_BITS-1:0] mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/perceptron_branch_predictor.sv
// ----------------------------------------------------------------------------
// perceptron_branch_predictor
// Perceptron predictor with a row-wide weight memory and read-modify-write.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action, pc and outcome; output
//   channel (out_valid/out_ready) returns prediction and weights_updated, one
//   item per input item, in order. theta is written over the APB port at
//   byte address 0.
//   One item is processed at a time. The row hash is pc*19; with a
//   power-of-two row count the row is its low bits, otherwise a remainder
//   unit reduces it 8 bits per cycle in the S_MOD state before the read.
//   Predict: memory read, partial-sum stage, final sum; then the result goes
//   to the output register and the block returns to idle for the next item.
//   Train: memory read, then update and write back of the row; the result
//   goes to the output register as the row is written, then the block idles.
//   The registered row memory read and the two-level adder tree set these steps.
//   After reset a clearing pass zeroes the memory, one row per cycle, and
//   in_ready stays low meanwhile. APB writes are taken.
//   A stalled receiver holds the result in the output register; the block
//   waits with the finished item and commits it when the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "perceptron_branch_predictor_macros.svh"

module perceptron_branch_predictor
    import pbp_pkg::*;
#(
    parameter int HISTORY_LEN = 32,
    parameter int TABLE_ROWS  = 256,
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  action,
    input  wire logic [31:0]           pc,
    input  wire logic                  outcome,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       prediction,
    output logic                       weights_updated
);

    localparam int ROW_LEN   = HISTORY_LEN + 1;
    localparam int ROW_BITS  = ROW_LEN * WEIGHT_BITS;
    localparam int ROW_W     = $clog2(TABLE_ROWS);
    localparam bit ROWS_POW2 = (TABLE_ROWS & (TABLE_ROWS - 1)) == 0;
    localparam int TERM_W    = WEIGHT_BITS + 1;
    localparam int GRP       = 8;
    localparam int NG        = (ROW_LEN + GRP - 1) / GRP;
    localparam int PART_W    = WEIGHT_BITS + 4;
    localparam int SUM_W     = WEIGHT_BITS + $clog2(ROW_LEN) + 1;
    localparam int CMP_W     = ((SUM_W > THETA_W) ? SUM_W : THETA_W) + 1;
    localparam int MOD_STEPS = 4;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CALC = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    logic [2:0]             state_reg, state_next;
    logic [ROW_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [1:0]             step_reg, step_next;
    logic [THETA_W-1:0]     theta_reg, theta_next;
    logic [HISTORY_LEN-1:0] hist_reg, hist_next;
    logic                   latched_reg, latched_next;
    logic                   needs_reg, needs_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   pred_reg, pred_next;
    logic                   upd_reg, upd_next;

    logic                   act_reg;
    logic                   outc_reg;
    logic [31:0]            hash_reg;
    logic [ROW_W-1:0]       rem_reg;
    logic [ROW_W-1:0]       row_reg;
    logic signed [PART_W-1:0] part_reg [NG];

    logic                   cfg_wr;
    logic                   in_fire;
    logic                   commit;
    logic                   train_upd;
    logic [ROW_W-1:0]       row_idx;
    logic [ROW_W-1:0]       rem_step;
    logic [ROW_BITS-1:0]    rd_row;
    logic [ROW_BITS-1:0]    new_row;
    logic                   ram_we;
    logic [ROW_W-1:0]       ram_waddr;
    logic [ROW_BITS-1:0]    ram_wdata;
    logic signed [TERM_W-1:0] term [ROW_LEN];
    logic signed [PART_W-1:0] part_c [NG];
    logic signed [SUM_W-1:0]  sum_c;
    logic signed [CMP_W-1:0]  sum_x;
    logic signed [CMP_W-1:0]  th_x;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_THETA);
    assign prdata = (paddr[2] == REG_THETA) ? APB_DATA_W'(theta_reg) : '0;

    assign in_ready        = (state_reg == S_IDLE);
    assign in_fire         = in_valid && in_ready;
    assign out_valid       = out_valid_reg;
    assign prediction      = pred_reg;
    assign weights_updated = upd_reg;

    // remainder by TABLE_ROWS, 8 hash bits per step, MSB first
    always_comb
    begin
        logic [ROW_W:0] t;
        rem_step = rem_reg;
        for (int b = 0; b < 8; b++)
        begin
            t = {rem_step, hash_reg[31 - b]};
            if (t >= (ROW_W+1)'(TABLE_ROWS))
            begin
                t = t - (ROW_W+1)'(TABLE_ROWS);
            end
            rem_step = t[ROW_W-1:0];
        end
    end

    assign row_idx = ROWS_POW2 ? hash_reg[ROW_W-1:0] : rem_reg;

    // per-weight terms and updates
    for (genvar i = 0; i < ROW_LEN; i++)
    begin : g_lane
        logic signed [WEIGHT_BITS-1:0] w;
        logic                          pos;
        logic                          up;
        assign w = rd_row[i*WEIGHT_BITS +: WEIGHT_BITS];
        if (i == 0)
        begin : g_bias
            assign pos = 1'b1;
            assign up  = outc_reg;
        end
        else
        begin : g_hist
            assign pos = hist_reg[i-1];
            assign up  = (hist_reg[i-1] == outc_reg);
        end
        assign term[i] = pos ? TERM_W'(w) : -TERM_W'(w);
        always_comb
        begin
            if (up)
            begin
                new_row[i*WEIGHT_BITS +: WEIGHT_BITS] = (w == W_MAX) ? w : w + WEIGHT_BITS'(1);
            end
            else
            begin
                new_row[i*WEIGHT_BITS +: WEIGHT_BITS] = (w == W_MIN) ? w : w - WEIGHT_BITS'(1);
            end
        end
    end

    // first tree level: groups of eight terms
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            part_c[g] = '0;
            for (int k = 0; k < GRP; k++)
            begin
                if (g * GRP + k < ROW_LEN)
                begin
                    part_c[g] = part_c[g] + PART_W'(term[g * GRP + k]);
                end
            end
        end
    end

    // second tree level
    always_comb
    begin
        sum_c = '0;
        for (int g = 0; g < NG; g++)
        begin
            sum_c = sum_c + SUM_W'(part_reg[g]);
        end
    end

    assign sum_x = CMP_W'(sum_c);
    assign th_x  = signed'(CMP_W'(theta_reg));

    assign train_upd = (latched_reg != outc_reg) || needs_reg;
    assign commit    = ((state_reg == S_CALC && act_reg == ACT_TRAIN) || state_reg == S_FIN)
                       && (!out_valid_reg || out_ready);

    assign ram_we    = (state_reg == S_CLR) ||
                       (commit && state_reg == S_CALC && train_upd);
    assign ram_waddr = (state_reg == S_CLR) ? clr_cnt_reg : row_reg;
    assign ram_wdata = (state_reg == S_CLR) ? '0 : new_row;

    pbp_row_ram #(
        .ROWS     (TABLE_ROWS),
        .ROW_BITS (ROW_BITS),
        .ADDR_W   (ROW_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == S_RD),
        .raddr (row_idx),
        .rdata (rd_row)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        step_next      = step_reg;
        theta_next     = cfg_wr ? pwdata[THETA_W-1:0] : theta_reg;
        hist_next      = hist_reg;
        latched_next   = latched_reg;
        needs_next     = needs_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pred_next      = pred_reg;
        upd_next       = upd_reg;

        if (commit)
        begin
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
            if (state_reg == S_FIN)
            begin
                latched_next = (sum_c >= 0);
                needs_next   = (sum_x < th_x) && (sum_x > -th_x);
                pred_next    = (sum_c >= 0);
                upd_next     = 1'b0;
            end
            else
            begin
                hist_next = HISTORY_LEN'({hist_reg, outc_reg});
                pred_next = latched_reg;
                upd_next  = train_upd;
            end
        end

        case (state_reg)
            S_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_W'(TABLE_ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                step_next = '0;
                if (in_fire)
                begin
                    state_next = ROWS_POW2 ? S_RD : S_MOD;
                end
            end
            S_MOD:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 2'(MOD_STEPS - 1))
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (act_reg == ACT_PREDICT)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            step_reg      <= '0;
            theta_reg     <= THETA_RESET;
            hist_reg      <= '0;
            latched_reg   <= 1'b0;
            needs_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            pred_reg      <= 1'b0;
            upd_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            step_reg      <= step_next;
            theta_reg     <= theta_next;
            hist_reg      <= hist_next;
            latched_reg   <= latched_next;
            needs_reg     <= needs_next;
            out_valid_reg <= out_valid_next;
            pred_reg      <= pred_next;
            upd_reg       <= upd_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg  <= action;
            outc_reg <= outcome;
            hash_reg <= pc * HASH_MUL;
            rem_reg  <= '0;
        end
        else if (state_reg == S_MOD)
        begin
            hash_reg <= {hash_reg[23:0], 8'd0};
            rem_reg  <= rem_step;
        end
        if (state_reg == S_RD)
        begin
            row_reg <= row_idx;
        end
        if (state_reg == S_CALC)
        begin
            part_reg <= part_c;
        end
    end

    `PBP_ASSERT_IMP(a_we_src, ram_we,
        state_reg == S_CLR || (state_reg == S_CALC && act_reg == ACT_TRAIN),
        "row write outside clear pass or train commit")
    `PBP_ASSERT_NXT(a_hist_hold, state_reg != S_CALC, $stable(hist_reg),
        "history changed without a train commit")
    `PBP_ASSERT_NXT(a_pred_no_upd, commit && state_reg == S_FIN,
        out_valid_reg && !upd_reg,
        "predict item reported a weight update")
    `PBP_ASSERT_NXT(a_clr_done, state_reg == S_CLR && clr_cnt_reg == ROW_W'(TABLE_ROWS - 1),
        state_reg == S_IDLE,
        "clearing pass did not end after the last row")

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for perceptron_branch_predictor. A scoreboard class
// keeps its own weight table, history and latched state, predicts one result
// per accepted item and checks results in order. Directed branches, weight
// saturation runs and random predict/train streams run under several theta
// settings, with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import pbp_pkg::*;
();

    localparam int HIST_LEN    = 32;
    localparam int ROWS        = 256;
    localparam int WBITS       = 8;
    localparam int ROW_LEN     = HIST_LEN + 1;
    localparam int W_MAX       = 127;
    localparam int W_MIN       = -128;
    localparam int THETA_MAX   = 4224;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 90;
    localparam int SAT_TRAINS  = 135;

    localparam logic [APB_ADDR_W-1:0] ADDR_THETA = APB_ADDR_W'(4 * REG_THETA);
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = ADDR_THETA + 3'd4;

    typedef struct packed {
        logic prediction;
        logic weights_updated;
    } pbp_result_t;

    class pbp_scoreboard;
        logic signed [WBITS-1:0] wt [ROWS][ROW_LEN];
        logic [HIST_LEN-1:0]     ghist;
        logic                    latched_taken;
        logic                    train_pending;
        logic [THETA_W-1:0]      theta;
        pbp_result_t             expected_q [$];
        int                      errors;
        int                      n_predict;
        int                      n_train;
        int                      n_updates;
        int                      n_checked;

        function new();
            foreach (wt[r, i])
                wt[r][i] = '0;
            ghist         = '0;
            latched_taken = 1'b0;
            train_pending = 1'b0;
            theta         = THETA_RESET;
            errors        = 0;
            n_predict     = 0;
            n_train       = 0;
            n_updates     = 0;
            n_checked     = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int unsigned row_of(logic [31:0] p);
            logic [31:0] h;
            h = p * HASH_MUL;
            return h % ROWS;
        endfunction

        function logic signed [WBITS-1:0] nudge(logic signed [WBITS-1:0] w, logic up);
            if (up)
                return (int'(w) == W_MAX) ? w : WBITS'(int'(w) + 1);
            return (int'(w) == W_MIN) ? w : WBITS'(int'(w) - 1);
        endfunction

        function void note_item(logic act, logic [31:0] p, logic oc);
            int unsigned r;
            int          sum;
            int          th;
            logic        upd;
            pbp_result_t res;
            r = row_of(p);
            if (act == ACT_PREDICT)
            begin
                sum = int'(wt[r][0]);
                for (int i = 1; i < ROW_LEN; i++)
                    sum += ghist[i-1] ? int'(wt[r][i]) : -int'(wt[r][i]);
                th            = int'(theta);
                latched_taken = (sum >= 0);
                train_pending = (sum < th) && (sum > -th);
                res.prediction      = latched_taken;
                res.weights_updated = 1'b0;
                n_predict++;
            end
            else
            begin
                upd = (latched_taken != oc) || train_pending;
                if (upd)
                begin
                    wt[r][0] = nudge(wt[r][0], oc);
                    for (int i = 1; i < ROW_LEN; i++)
                        wt[r][i] = nudge(wt[r][i], ghist[i-1] == oc);
                    n_updates++;
                end
                ghist = {ghist[HIST_LEN-2:0], oc};
                res.prediction      = latched_taken;
                res.weights_updated = upd;
                n_train++;
            end
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("tb: mismatch: %s", msg);
        endtask

        task check_result(logic pred, logic upd);
            pbp_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing expected", n_checked));
            end
            else
            begin
                want = expected_q.pop_front();
                if (pred !== want.prediction)
                    report_mismatch($sformatf("result %0d prediction %b, expected %b",
                                              n_checked, pred, want.prediction));
                if (upd !== want.weights_updated)
                    report_mismatch($sformatf("result %0d weights_updated %b, expected %b",
                                              n_checked, upd, want.weights_updated));
            end
            n_checked++;
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic                  action;
    logic [31:0]           pc;
    logic                  outcome;
    logic                  out_valid;
    logic                  out_ready;
    logic                  prediction;
    logic                  weights_updated;

    pbp_scoreboard sb;
    bit            no_idle     = 1'b0;
    bit            hold_req    = 1'b0;
    int            quiet_count = 0;
    int            n_settings  = 0;

    perceptron_branch_predictor dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .pc              (pc),
        .outcome         (outcome),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .prediction      (prediction),
        .weights_updated (weights_updated)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls plus one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(prediction, weights_updated);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 99) < 25)
            begin
                stall_left = idle_len() - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
    end

    initial
    begin
        wait (quiet_count >= QUIET_LIMIT);
        $display("tb: no progress for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic send_item(input logic act, input logic [31:0] p, input logic oc);
        int gap;
        in_valid <= 1'b1;
        action   <= act;
        pc       <= p;
        outcome  <= oc;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(act, p, oc);
        gap = (no_idle || $urandom_range(0, 99) >= 30) ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_theta();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, ADDR_THETA, '0, rd);
        if (rd !== APB_DATA_W'(sb.theta))
            sb.report_mismatch($sformatf("theta reads %0d, expected %0d", rd, sb.theta));
    endtask

    task automatic write_theta(input logic [APB_DATA_W-1:0] v);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, ADDR_THETA, v, rd);
        sb.theta = v[THETA_W-1:0];
        n_settings++;
        check_theta();
    endtask

    task automatic run_phase(input int n_items);
        logic [31:0] pool [6];
        logic        lean [6];
        logic [31:0] p;
        logic        o;
        int          start;
        int          k;
        int          r;
        for (int i = 0; i < 6; i++)
        begin
            pool[i] = $urandom();
            lean[i] = $urandom_range(0, 1);
        end
        start = sb.n_predict + sb.n_train;
        while (sb.n_predict + sb.n_train - start < n_items)
        begin
            k = $urandom_range(0, 5);
            p = ($urandom_range(0, 9) < 8) ? pool[k] : $urandom();
            o = ($urandom_range(0, 9) < 8) ? lean[k] : 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                send_item(ACT_PREDICT, p, 1'($urandom_range(0, 1)));
                send_item(ACT_TRAIN, p, o);
            end
            else if (r < 85)
            begin
                send_item(ACT_TRAIN, p, o);
            end
            else if (r < 93)
            begin
                send_item(ACT_PREDICT, p, 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_item(ACT_PREDICT, p, 1'($urandom_range(0, 1)));
                send_item(ACT_TRAIN, $urandom(), o);
            end
        end
    endtask

    initial
    begin
        logic [31:0]           sat_pc;
        logic [APB_DATA_W-1:0] rd;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        action   = ACT_PREDICT;
        pc       = '0;
        outcome  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        sb       = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_theta();

        // train before any predict, then a repeated train
        send_item(ACT_TRAIN,   32'hFFFF_FFFF, 1'b1);
        send_item(ACT_TRAIN,   32'hFFFF_FFFF, 1'b0);
        send_item(ACT_PREDICT, 32'h0000_0000, 1'b0);
        send_item(ACT_TRAIN,   32'h0000_0000, 1'b0);
        send_item(ACT_TRAIN,   32'h0000_0000, 1'b0);
        // train on a different pc than the predict
        send_item(ACT_PREDICT, 32'h1234_5678, 1'b1);
        send_item(ACT_TRAIN,   32'h8765_4321, 1'b1);
        send_item(ACT_PREDICT, 32'hFFFF_FFFF, 1'b0);
        send_item(ACT_TRAIN,   32'hFFFF_FFFF, 1'b1);
        send_item(ACT_PREDICT, 32'hAAAA_AAAA, 1'b1);
        send_item(ACT_TRAIN,   32'hAAAA_AAAA, 1'b0);
        send_item(ACT_PREDICT, 32'h5555_5555, 1'b0);
        send_item(ACT_TRAIN,   32'h5555_5555, 1'b1);
        send_item(ACT_PREDICT, 32'h0000_0000, 1'b1);
        send_item(ACT_TRAIN,   32'h0000_0000, 1'b1);
        drain();

        write_theta(32'd0);
        send_item(ACT_PREDICT, 32'h0000_0000, 1'b0);
        send_item(ACT_TRAIN,   32'h0000_0000, 1'b1);
        send_item(ACT_PREDICT, 32'hFFFF_FFFF, 1'b0);
        send_item(ACT_TRAIN,   32'hFFFF_FFFF, 1'b0);
        drain();

        // a write to a register index other than theta must leave theta alone
        apb_access(1'b1, ADDR_SPARE, 32'h0000_1FFF, rd);
        check_theta();

        // large theta: a predict asks for training unless its sum is -THETA_MAX; drive a bias to both limits
        write_theta({19'($urandom_range(0, 'h7FFFF)), 13'(THETA_MAX)});
        no_idle  = 1'b1;
        hold_req = 1'b1;
        sat_pc   = $urandom();
        send_item(ACT_PREDICT, sat_pc, 1'b0);
        for (int i = 0; i < SAT_TRAINS; i++)
            send_item(ACT_TRAIN, sat_pc, 1'b1);
        send_item(ACT_PREDICT, sat_pc, 1'b0);
        no_idle = 1'b0;
        drain();
        sat_pc = $urandom();
        send_item(ACT_PREDICT, sat_pc, 1'b1);
        for (int i = 0; i < SAT_TRAINS; i++)
        begin
            send_item(ACT_TRAIN, sat_pc, 1'b0);
            if (i == SAT_TRAINS / 2)
                drain();
        end
        send_item(ACT_PREDICT, sat_pc, 1'b1);
        drain();

        write_theta(32'd0);
        run_phase(PHASE_ITEMS);
        drain();
        write_theta(32'(THETA_MAX));
        no_idle = 1'b1;
        run_phase(PHASE_ITEMS);
        no_idle = 1'b0;
        drain();
        write_theta($urandom_range(1, 200));
        run_phase(PHASE_ITEMS);
        drain();
        write_theta($urandom_range(0, THETA_MAX));
        run_phase(PHASE_ITEMS);
        drain();
        repeat (20) @(posedge clk);

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        $display("tb: checked %0d predicts and %0d trains, %0d of them updating weights",
                 sb.n_predict, sb.n_train, sb.n_updates);
        $display("tb: %0d theta writes from 0 to %0d, bias driven to both limits, %0d-cycle hold",
                 n_settings, THETA_MAX, HOLD_CYCLES);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
